// ===== rtl/mpq_pkg.sv =====
// Package for the min-priority queue unit: request and status codes and the
// command struct that the controller sends to the datapath. No dependencies.
package mpq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_EMPTY_RMV  = 2'd1;
  localparam logic [1:0] STATUS_FULL_INS   = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } mpq_cmd_t;

endpackage

// ===== rtl/min_priority_queue_unit.sv =====
// Top level of the min-priority queue unit: joins the controller and the
// datapath. Depends on mpq_pkg, mpq_ctrl and mpq_datapath.
//
// A bounded min-priority queue of signed 32-bit keys. Each item either inserts
// a key or removes the smallest one, and yields exactly one result with the
// removed key, the new minimum, the count, an empty flag and a status code.
// An item is accepted in the idle state, and then in the exec state every
// cell of the sorted key row compares against the key and shifts at once.
// The next item is accepted no earlier than the cycle in which the previous
// result is taken, so a new item never enters while the previous one is
// executing. There is no clearing pass after reset.
module min_priority_queue_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic signed [mpq_pkg::KEY_W-1:0]    key,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mpq_pkg::KEY_W-1:0]    removed_key,
  output logic signed [mpq_pkg::KEY_W-1:0]    min_key,
  output logic        [mpq_pkg::COUNT_W-1:0]  held_count,
  output logic                                is_empty,
  output logic        [1:0]                   status
);

  mpq_pkg::mpq_cmd_t cmd;

  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req_type),
    .key         (key),
    .removed_key (removed_key),
    .min_key     (min_key),
    .held_count  (held_count),
    .is_empty    (is_empty),
    .status      (status)
  );

endmodule

// ===== rtl/mpq_ctrl.sv =====
// Controller of the min-priority queue unit: a two-state machine and the
// output valid flag. Depends on mpq_pkg for the command struct.
module mpq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output mpq_pkg::mpq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign cmd.load = in_valid && in_ready;
  assign cmd.exec = (state == S_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/mpq_datapath.sv =====
// Datapath of the min-priority queue unit: a sorted row of key cells with a
// comparator per cell, the fill count and the result registers. Uses mpq_pkg.
module mpq_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mpq_pkg::mpq_cmd_t                   cmd,
  input  logic                                req_type,
  input  logic signed [mpq_pkg::KEY_W-1:0]    key,
  output logic signed [mpq_pkg::KEY_W-1:0]    removed_key,
  output logic signed [mpq_pkg::KEY_W-1:0]    min_key,
  output logic        [mpq_pkg::COUNT_W-1:0]  held_count,
  output logic                                is_empty,
  output logic        [1:0]                   status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [mpq_pkg::KEY_W-1:0] cells [CAPACITY];
  logic signed [mpq_pkg::KEY_W-1:0] key_q;
  logic                             req_q;
  logic        [CNT_W-1:0]          count;
  logic        [CNT_W-1:0]          count_next;
  logic        [CAPACITY-1:0]       gt;
  logic                             full;
  logic                             empty;
  logic                             do_insert;
  logic                             do_remove;
  logic signed [mpq_pkg::KEY_W-1:0] removed_next;
  logic signed [mpq_pkg::KEY_W-1:0] min_next;
  logic        [1:0]                status_next;

  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign do_insert = (req_q == mpq_pkg::REQ_INSERT) && !full;
  assign do_remove = (req_q == mpq_pkg::REQ_REMOVE) && !empty;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q <= key;
      req_q <= req_type;
    end
  end

  // Each held cell reports whether the new key sorts ahead of it; the row is
  // sorted, so these flags switch from low to high at most once.
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      assign gt[i] = (count > CNT_W'(i)) && (key_q < cells[i]);

      if (i == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (cmd.exec) begin
            if (do_insert) begin
              if (gt[i] || (count == CNT_W'(i))) cells[i] <= key_q;
            end else if (do_remove) begin
              cells[i] <= cells[i+1];
            end
          end
        end
      end else if (i == CAPACITY - 1) begin : g_last
        always_ff @(posedge clk) begin
          if (cmd.exec && do_insert) begin
            if (gt[i-1]) begin
              cells[i] <= cells[i-1];
            end else if (gt[i] || (count == CNT_W'(i))) begin
              cells[i] <= key_q;
            end
          end
        end
      end else begin : g_mid
        always_ff @(posedge clk) begin
          if (cmd.exec) begin
            if (do_insert) begin
              if (gt[i-1]) begin
                cells[i] <= cells[i-1];
              end else if (gt[i] || (count == CNT_W'(i))) begin
                cells[i] <= key_q;
              end
            end else if (do_remove) begin
              cells[i] <= cells[i+1];
            end
          end
        end
      end
    end
  endgenerate

  always_comb begin
    count_next   = count;
    removed_next = '0;
    min_next     = empty ? '0 : cells[0];
    status_next  = mpq_pkg::STATUS_OK;
    if (req_q == mpq_pkg::REQ_INSERT) begin
      if (full) begin
        status_next = mpq_pkg::STATUS_FULL_INS;
      end else begin
        count_next = count + CNT_W'(1);
        if (empty || gt[0]) min_next = key_q;
      end
    end else begin
      if (empty) begin
        status_next = mpq_pkg::STATUS_EMPTY_RMV;
      end else begin
        count_next   = count - CNT_W'(1);
        removed_next = cells[0];
        min_next     = (count > CNT_W'(1)) ? cells[1] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      removed_key <= removed_next;
      min_key     <= min_next;
      held_count  <= mpq_pkg::COUNT_W'(count_next);
      is_empty    <= (count_next == '0);
      status      <= status_next;
    end
  end

endmodule

// ===== dv/min_priority_queue_unit_test.sv =====
// Testbench for min_priority_queue_unit: sends insert and remove items under random
// pacing and checks every result against a sorted-array model of the queue.
// Depends on mpq_pkg and the RTL of min_priority_queue_unit.
module min_priority_queue_unit_test;

  localparam int CAPACITY       = 64;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int TAIL_CYCLES    = 4;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [mpq_pkg::KEY_W-1:0]   removed;
    logic [mpq_pkg::KEY_W-1:0]   minimum;
    logic [mpq_pkg::COUNT_W-1:0] count;
    logic                        empty;
    logic [1:0]                  status;
  } queue_result_t;

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               in_valid  = 1'b0;
  logic                               req_type  = mpq_pkg::REQ_INSERT;
  logic signed [mpq_pkg::KEY_W-1:0]   key       = '0;
  logic                               out_ready = 1'b0;
  logic                               in_ready;
  logic                               out_valid;
  logic signed [mpq_pkg::KEY_W-1:0]   removed_key;
  logic signed [mpq_pkg::KEY_W-1:0]   min_key;
  logic        [mpq_pkg::COUNT_W-1:0] held_count;
  logic                               is_empty;
  logic        [1:0]                  status;

  logic signed [mpq_pkg::KEY_W-1:0] sorted_keys [CAPACITY];
  int                               held_keys   = 0;
  queue_result_t                    pending_results [$];
  int                               fault_count = 0;
  int                               idle_cycles = 0;
  int                               burst_left  = 0;
  int                               rcv_tick    = 0;
  int                               rcv_hold    = 0;

  min_priority_queue_unit #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .key(key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .removed_key(removed_key),
    .min_key(min_key),
    .held_count(held_count),
    .is_empty(is_empty),
    .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The queue is modelled as an array kept in ascending order, so the smallest key
  // always sits in the first entry.
  function automatic queue_result_t apply_request(logic req,
                                                  logic signed [mpq_pkg::KEY_W-1:0] k);
    queue_result_t r;
    int i;
    r = '0;
    if (req == mpq_pkg::REQ_INSERT) begin
      if (held_keys >= CAPACITY) begin
        r.status = mpq_pkg::STATUS_FULL_INS;
      end else begin
        i = held_keys;
        while (i > 0 && k < sorted_keys[i-1]) begin
          sorted_keys[i] = sorted_keys[i-1];
          i--;
        end
        sorted_keys[i] = k;
        held_keys++;
        r.status = mpq_pkg::STATUS_OK;
      end
    end else begin
      if (held_keys == 0) begin
        r.status = mpq_pkg::STATUS_EMPTY_RMV;
      end else begin
        r.removed = sorted_keys[0];
        for (i = 1; i < held_keys; i++) sorted_keys[i-1] = sorted_keys[i];
        held_keys--;
        r.status = mpq_pkg::STATUS_OK;
      end
    end
    r.minimum = (held_keys > 0) ? sorted_keys[0] : '0;
    r.count   = mpq_pkg::COUNT_W'(held_keys);
    r.empty   = (held_keys == 0);
    return r;
  endfunction

  function automatic logic signed [mpq_pkg::KEY_W-1:0] pick_key();
    logic signed [mpq_pkg::KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0: k = 32'h8000_0000 + $urandom_range(0, 3);
      1: k = 32'h7FFF_FFFF - $urandom_range(0, 3);
      2, 3: k = $urandom_range(0, 16) - 8;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(input logic req, input logic signed [mpq_pkg::KEY_W-1:0] k);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid = 1'b1;
    req_type = req;
    key      = k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_remove();
    send_item(mpq_pkg::REQ_REMOVE, 32'h0000_0000);
    send_item(mpq_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
    send_item(mpq_pkg::REQ_REMOVE, 32'h8000_0000);
  endtask

  task automatic test_key_extremes();
    logic signed [mpq_pkg::KEY_W-1:0] extremes [9] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
    };
    foreach (extremes[i]) send_item(mpq_pkg::REQ_INSERT, extremes[i]);
    repeat (10) send_item(mpq_pkg::REQ_REMOVE, pick_key());
  endtask

  task automatic test_fill_to_capacity(input int rounds);
    int n;
    repeat (rounds) begin
      n = CAPACITY - held_keys;
      repeat (n + 3) send_item(mpq_pkg::REQ_INSERT, pick_key());
      repeat (CAPACITY + 3) send_item(mpq_pkg::REQ_REMOVE, pick_key());
    end
  endtask

  // The insert share changes every hundred items so that the count sweeps between
  // empty and full.
  task automatic test_random_mix(input int count);
    int insert_pct;
    insert_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        case ((i / 100) % 4)
          0: insert_pct = 85;
          1: insert_pct = 25;
          2: insert_pct = 50;
          default: insert_pct = 95;
        endcase
      end
      send_item(($urandom_range(1, 100) <= insert_pct) ? mpq_pkg::REQ_INSERT
                                                       : mpq_pkg::REQ_REMOVE,
                pick_key());
    end
  endtask

  task automatic test_duplicate_keys(input int count);
    repeat (count) begin
      send_item(($urandom_range(1, 100) <= 60) ? mpq_pkg::REQ_INSERT : mpq_pkg::REQ_REMOVE,
                $urandom_range(0, 6) - 3);
    end
  endtask

  // The receiver cycles through always ready, random stalls, a sparse pattern and
  // long stalls.
  always @(negedge clk) begin
    rcv_tick++;
    case ((rcv_tick / 97) % 4)
      0: out_ready = 1'b1;
      1: out_ready = ($urandom_range(0, 1) == 1);
      2: out_ready = (rcv_tick % 5 == 0);
      default: begin
        if (rcv_hold > 0) begin
          out_ready = 1'b0;
          rcv_hold--;
        end else begin
          out_ready = 1'b1;
          if ($urandom_range(0, 7) == 0) rcv_hold = $urandom_range(4, 15);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    queue_result_t want;
    logic moved;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        pending_results.insert(pending_results.size(), apply_request(req_type, key));
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          note_fault($sformatf("result with nothing pending: removed_key %0d status %0d",
                               removed_key, status));
        end else begin
          want = pending_results.pop_front();
          if (removed_key !== want.removed)
            note_fault($sformatf("removed_key expected %0d got %0d",
                                 $signed(want.removed), removed_key));
          if (min_key !== want.minimum)
            note_fault($sformatf("min_key expected %0d got %0d",
                                 $signed(want.minimum), min_key));
          if (held_count !== want.count)
            note_fault($sformatf("held_count expected %0d got %0d", want.count, held_count));
          if (is_empty !== want.empty)
            note_fault($sformatf("is_empty expected %0d got %0d", want.empty, is_empty));
          if (status !== want.status)
            note_fault($sformatf("status expected %0d got %0d", want.status, status));
        end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_remove();
    wait_for_results();
    test_key_extremes();
    wait_for_results();
    test_fill_to_capacity(2);
    wait_for_results();
    test_random_mix(800);
    wait_for_results();
    test_duplicate_keys(400);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
